/* rtl/prss_pkg.sv */
// Package for the periodic report slot scheduler.
// Holds the item structs, action and status codes, controller states and
// the command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package prss_pkg;

	localparam logic [1:0] ACT_TICK   = 2'd0;
	localparam logic [1:0] ACT_ADD    = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;

	localparam logic [2:0] ST_DUE            = 3'd0;
	localparam logic [2:0] ST_NONE_DUE       = 3'd1;
	localparam logic [2:0] ST_ADDED          = 3'd2;
	localparam logic [2:0] ST_UPDATED        = 3'd3;
	localparam logic [2:0] ST_ADD_REJECT     = 3'd4;
	localparam logic [2:0] ST_REMOVED        = 3'd5;
	localparam logic [2:0] ST_REMOVE_IGNORED = 3'd6;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] now_ms;
		logic [3:0]  module_type;
		logic [31:0] interval_ms;
		logic        handler_present;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] module_type_res;
		logic       last;
	} out_item_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic step;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic last_slot;
		logic need_push;
		logic out_free;
		logic no_result;
	} dp_status_t;

endpackage

/* rtl/periodic_report_slot_scheduler_unit.sv */
// Top level of the periodic report slot scheduler.
// An item's final result is offered after a scan of one table slot per cycle and
// a closing step; an output stall can pause either the scan or the closing step.
// A new item is accepted only after the previous one's closing step.
// Reset (arst_n low, asynchronous) empties the table and clears all handshakes.
// Depends on prss_pkg, prss_ctrl and prss_datapath.
`timescale 1ns / 1ps

module periodic_report_slot_scheduler_unit #(
	parameter int SLOTS            = 8,
	parameter int FIRST_VALID_TYPE = 1,
	parameter int TYPE_LIMIT       = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  prss_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output prss_pkg::out_item_t out_item
);
	import prss_pkg::*;

	// The controller walks three phases: idle (ready for an item), scan (one table
	// slot per cycle, held while a due result waits for output) and done (the closing
	// result is written and any table update for add or remove is applied).
	dp_cmd_t    cmd;
	dp_status_t status;

	prss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// During a tick each due slot is re-stamped as it is scanned. Its result is
	// held back, because whether it is the final one is known only when
	// the next due slot appears or the scan ends. The output register lets the
	// block accept the next item while a result still waits to be taken.
	prss_datapath #(
		.SLOTS            (SLOTS),
		.FIRST_VALID_TYPE (FIRST_VALID_TYPE),
		.TYPE_LIMIT       (TYPE_LIMIT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

/* rtl/prss_ctrl.sv */
// Controller state machine of the report slot scheduler.
// Sequences capture, the slot scan and the final result; uses prss_pkg.
`timescale 1ns / 1ps

module prss_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  prss_pkg::dp_status_t status,
	output prss_pkg::dp_cmd_t    cmd
);
	import prss_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd.start  = 1'b0;
		cmd.step   = 1'b0;
		cmd.finish = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				// A second due slot must wait until the output register can take
				// the one held back before it.
				if (!(status.need_push && !status.out_free)) begin
					cmd.step = 1'b1;
					if (status.last_slot) begin
						state_d = S_DONE;
					end
				end
			end
			S_DONE: begin
				if (status.out_free || status.no_result) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* rtl/prss_datapath.sv */
// Datapath of the report slot scheduler: slot table, scan index, match and
// free-slot trackers, held-back due result and output register. Uses prss_pkg.
`timescale 1ns / 1ps

module prss_datapath #(
	parameter int SLOTS            = 8,
	parameter int FIRST_VALID_TYPE = 1,
	parameter int TYPE_LIMIT       = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  prss_pkg::in_item_t   in_item,
	input  prss_pkg::dp_cmd_t    cmd,
	output prss_pkg::dp_status_t status,
	output logic                 out_valid,
	input  logic                 out_ready,
	output prss_pkg::out_item_t  out_item
);
	import prss_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [SLOTS-1:0] used_q;
	logic [3:0]       module_q [SLOTS];
	logic [31:0]      period_q [SLOTS];
	logic [31:0]      stamp_q  [SLOTS];

	in_item_t  req_q;
	logic [IW-1:0] idx_q;
	logic      match_found_q, free_found_q, pend_valid_q;
	logic [IW-1:0] match_idx_q, free_idx_q;
	logic [3:0] pend_mod_q;
	logic      out_valid_q;
	out_item_t out_q;

	logic        cur_used, due, match, type_ok, add_ok, is_tick;
	logic [31:0] elapsed;
	logic        push;
	out_item_t   push_item;
	logic        wr_en, wr_new, set_used, clr_used;
	logic [IW-1:0] wr_idx;
	logic [31:0] wr_stamp;

	always_comb begin
		is_tick  = (req_q.action == ACT_TICK);
		cur_used = used_q[idx_q];
		elapsed  = req_q.now_ms - stamp_q[idx_q];
		due      = is_tick && cur_used && (elapsed >= period_q[idx_q]);
		match    = cur_used && (module_q[idx_q] == req_q.module_type);
		type_ok  = ({1'b0, req_q.module_type} >= 5'(FIRST_VALID_TYPE)) &&
		           ({1'b0, req_q.module_type} < 5'(TYPE_LIMIT));
		add_ok   = req_q.handler_present && type_ok && (req_q.interval_ms != 32'd0);

		status.last_slot = (idx_q == IW'(SLOTS - 1));
		status.need_push = due && pend_valid_q;
		status.out_free  = !out_valid_q || out_ready;
		status.no_result = !((req_q.action == ACT_TICK) || (req_q.action == ACT_ADD) ||
		                     (req_q.action == ACT_REMOVE));

		push      = 1'b0;
		push_item = '{status: ST_DUE, module_type_res: pend_mod_q, last: 1'b0};
		wr_en     = 1'b0;
		wr_new    = 1'b0;
		set_used  = 1'b0;
		clr_used  = 1'b0;
		wr_idx    = idx_q;
		wr_stamp  = req_q.now_ms;

		if (cmd.step) begin
			if (due) begin
				wr_en = 1'b1;
				push  = pend_valid_q;
			end
		end else if (cmd.finish) begin
			case (req_q.action)
				ACT_TICK: begin
					push = 1'b1;
					if (pend_valid_q) begin
						push_item = '{status: ST_DUE, module_type_res: pend_mod_q, last: 1'b1};
					end else begin
						push_item = '{status: ST_NONE_DUE, module_type_res: 4'd0, last: 1'b1};
					end
				end
				ACT_ADD: begin
					push      = 1'b1;
					push_item = '{status: ST_ADD_REJECT, module_type_res: 4'd0, last: 1'b1};
					if (add_ok && match_found_q) begin
						wr_en     = 1'b1;
						wr_new    = 1'b1;
						wr_idx    = match_idx_q;
						push_item = '{status: ST_UPDATED, module_type_res: req_q.module_type,
						              last: 1'b1};
					end else if (add_ok && free_found_q) begin
						wr_en     = 1'b1;
						wr_new    = 1'b1;
						set_used  = 1'b1;
						wr_idx    = free_idx_q;
						push_item = '{status: ST_ADDED, module_type_res: req_q.module_type,
						              last: 1'b1};
					end
				end
				ACT_REMOVE: begin
					push = 1'b1;
					if (type_ok && match_found_q) begin
						clr_used  = 1'b1;
						wr_idx    = match_idx_q;
						push_item = '{status: ST_REMOVED, module_type_res: req_q.module_type,
						              last: 1'b1};
					end else begin
						push_item = '{status: ST_REMOVE_IGNORED, module_type_res: 4'd0,
						              last: 1'b1};
					end
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

	// Slot table contents; only read where the used bit is set.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			stamp_q[wr_idx] <= wr_stamp;
			if (wr_new) begin
				period_q[wr_idx] <= req_q.interval_ms;
			end
			if (set_used) begin
				module_q[wr_idx] <= req_q.module_type;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q       <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (set_used) begin
				used_q[wr_idx] <= 1'b1;
			end else if (clr_used) begin
				used_q[wr_idx] <= 1'b0;
			end
			if (cmd.start) begin
				pend_valid_q <= 1'b0;
			end else if (cmd.step && due) begin
				pend_valid_q <= 1'b1;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			idx_q         <= '0;
		end else if (cmd.start) begin
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			idx_q         <= '0;
		end else if (cmd.step) begin
			if (match && !match_found_q) begin
				match_found_q <= 1'b1;
			end
			if (!cur_used && !free_found_q) begin
				free_found_q <= 1'b1;
			end
			idx_q <= idx_q + IW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q <= in_item;
		end
		if (cmd.step) begin
			if (match && !match_found_q) begin
				match_idx_q <= idx_q;
			end
			if (!cur_used && !free_found_q) begin
				free_idx_q <= idx_q;
			end
			if (due) begin
				pend_mod_q <= module_q[idx_q];
			end
		end
		if (push) begin
			out_q <= push_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

/* rtl/prss_checker.sv */
// Port-level checker for the periodic report slot scheduler, with its bind.
// Uses prss_pkg status codes.
`timescale 1ns / 1ps

module prss_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input prss_pkg::in_item_t  in_item,
	input logic                out_valid,
	input logic                out_ready,
	input prss_pkg::out_item_t out_item
);
	import prss_pkg::*;

	// A result that is not taken stays offered unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// The block works on one item at a time while it scans the table.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted again during a scan");

	// Only due results of a tick can be followed by more results.
	a_not_last_is_due: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.last |-> out_item.status == ST_DUE)
		else $error("non-final result with a status other than due");

	// Rejected, ignored and empty-tick results carry no module type.
	a_zero_type: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.status == ST_NONE_DUE ||
		              out_item.status == ST_ADD_REJECT ||
		              out_item.status == ST_REMOVE_IGNORED)
		|-> out_item.module_type_res == 4'd0)
		else $error("module type set on a result that has none");

endmodule

bind periodic_report_slot_scheduler_unit prss_checker u_prss_checker (.*);

/* test/tb_periodic_report_slot_scheduler_unit.sv */
// Self-checking testbench for periodic_report_slot_scheduler_unit.
// It drives ticks, adds and removes through valid/ready, checks every result against a
// predictor of the slot table, and depends on prss_pkg and the scheduler RTL.
`timescale 1ns / 1ps

module tb_periodic_report_slot_scheduler_unit;

	import prss_pkg::*;

	localparam int NUM_SLOTS = 8;
	localparam int MIN_TYPE  = 1;
	localparam int TYPE_END  = 16;

	// Action code 3 has no name in the package; the block ignores it.
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_item;

	periodic_report_slot_scheduler_unit #(
		.SLOTS           (NUM_SLOTS),
		.FIRST_VALID_TYPE(MIN_TYPE),
		.TYPE_LIMIT      (TYPE_END)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	// The testbench's own copy of the slot table, updated as each item is accepted.
	logic        tbl_used   [NUM_SLOTS];
	logic [3:0]  tbl_type   [NUM_SLOTS];
	logic [31:0] tbl_period [NUM_SLOTS];
	logic [31:0] tbl_stamp  [NUM_SLOTS];
	int          tbl_count;

	// Reports the block still owes us, oldest first.
	out_item_t pending_reports[$];

	int fail_count;
	int items_sent;
	int ticks_sent;
	int reports_checked;
	int due_reports;
	int biggest_burst;
	int full_rejects;

	// Idle percentages for the current phase, read by the sender and the receiver.
	int send_idle_pct;
	int recv_stall_pct;

	// Running millisecond time used by the random traffic.
	logic [31:0] clock_ms;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Receiver: out_ready is redrawn at every falling edge.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	function automatic in_item_t make_item(input logic [1:0] action, input logic [31:0] now,
			input logic [3:0] mtype, input logic [31:0] interval, input logic handler);
		in_item_t it;
		it.action          = action;
		it.now_ms          = now;
		it.module_type     = mtype;
		it.interval_ms     = interval;
		it.handler_present = handler;
		return it;
	endfunction

	function automatic out_item_t make_report(input logic [2:0] status, input logic [3:0] mtype,
			input logic last);
		out_item_t r;
		r.status          = status;
		r.module_type_res = mtype;
		r.last            = last;
		return r;
	endfunction

	function automatic bit type_known(input logic [3:0] mtype);
		return int'(mtype) >= MIN_TYPE && int'(mtype) < TYPE_END;
	endfunction

	// Index of the used slot that holds mtype, or -1.
	function automatic int slot_of(input logic [3:0] mtype);
		int i;
		for (i = 0; i < NUM_SLOTS; i++) begin
			if (tbl_used[i] && tbl_type[i] == mtype)
				return i;
		end
		return -1;
	endfunction

	// Applies one accepted item to the table copy and queues the reports it causes.
	task automatic predict_reports(input in_item_t it);
		bit          due [NUM_SLOTS];
		logic [31:0] elapsed;
		int          n_due;
		int          k;
		int          i;
		int          hit;
		n_due = 0;
		k     = 0;
		hit   = -1;
		case (it.action)
			ACT_TICK: begin
				ticks_sent++;
				// Elapsed time is taken modulo 2^32, so a stamp from before a wrap still
				// counts forward correctly.
				for (i = 0; i < NUM_SLOTS; i++) begin
					elapsed = it.now_ms - tbl_stamp[i];
					due[i]  = tbl_used[i] && (elapsed >= tbl_period[i]);
					if (due[i]) begin
						tbl_stamp[i] = it.now_ms;
						n_due++;
					end
				end
				if (n_due == 0) begin
					pending_reports.push_back(make_report(ST_NONE_DUE, 4'd0, 1'b1));
				end else begin
					for (i = 0; i < NUM_SLOTS; i++) begin
						if (due[i]) begin
							k++;
							pending_reports.push_back(make_report(ST_DUE, tbl_type[i], k == n_due));
						end
					end
				end
				if (n_due > biggest_burst)
					biggest_burst = n_due;
			end
			ACT_ADD: begin
				if (!it.handler_present || !type_known(it.module_type) || it.interval_ms == 0) begin
					pending_reports.push_back(make_report(ST_ADD_REJECT, 4'd0, 1'b1));
				end else begin
					hit = slot_of(it.module_type);
					if (hit >= 0) begin
						// A type already present is updated in place, even in a full table.
						tbl_period[hit] = it.interval_ms;
						tbl_stamp[hit]  = it.now_ms;
						pending_reports.push_back(make_report(ST_UPDATED, it.module_type, 1'b1));
					end else if (tbl_count < NUM_SLOTS) begin
						for (i = 0; i < NUM_SLOTS && hit < 0; i++) begin
							if (!tbl_used[i])
								hit = i;
						end
						tbl_used[hit]   = 1'b1;
						tbl_type[hit]   = it.module_type;
						tbl_period[hit] = it.interval_ms;
						tbl_stamp[hit]  = it.now_ms;
						tbl_count++;
						pending_reports.push_back(make_report(ST_ADDED, it.module_type, 1'b1));
					end else begin
						full_rejects++;
						pending_reports.push_back(make_report(ST_ADD_REJECT, 4'd0, 1'b1));
					end
				end
			end
			ACT_REMOVE: begin
				hit = type_known(it.module_type) ? slot_of(it.module_type) : -1;
				if (hit >= 0) begin
					tbl_used[hit] = 1'b0;
					tbl_count--;
					pending_reports.push_back(make_report(ST_REMOVED, it.module_type, 1'b1));
				end else begin
					pending_reports.push_back(make_report(ST_REMOVE_IGNORED, 4'd0, 1'b1));
				end
			end
			default: begin
				// The unused action code leaves the table alone and produces nothing.
			end
		endcase
	endtask

	// Sends one item. It is entered and left at a falling edge; on return valid is still
	// high, so the caller either sends the next item or lowers valid in that same step.
	task automatic send_item(input in_item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_item  <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_reports(it);
		items_sent++;
		@(negedge clk);
	endtask

	// Stops sending and waits until the block has delivered every report it owes.
	task automatic drain_reports();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(negedge clk);
	endtask

	// Checker: every accepted report is compared with the oldest expected one.
	always @(posedge clk) begin : check_reports
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			reports_checked++;
			if (pending_reports.size() == 0) begin
				$error("unexpected report: status %0d, module_type_res %0d, last %0d",
					out_item.status, out_item.module_type_res, out_item.last);
				fail_count++;
			end else begin
				want = pending_reports.pop_front();
				if (want.status == ST_DUE)
					due_reports++;
				if (out_item.status !== want.status) begin
					$error("status mismatch: expected %0d, got %0d", want.status, out_item.status);
					fail_count++;
				end
				if (out_item.module_type_res !== want.module_type_res) begin
					$error("module_type_res mismatch: expected %0d, got %0d",
						want.module_type_res, out_item.module_type_res);
					fail_count++;
				end
				if (out_item.last !== want.last) begin
					$error("last mismatch: expected %0d, got %0d", want.last, out_item.last);
					fail_count++;
				end
			end
		end
	end

	task automatic test_empty_tick();
		// An empty table answers a tick with a single none-due report.
		send_item(make_item(ACT_TICK, 32'd0, 4'd0, 32'd0, 1'b0));
	endtask

	task automatic test_add_rejects();
		// Type below the first valid one, zero interval, and a missing handler.
		send_item(make_item(ACT_ADD, 32'd50, 4'd0, 32'd10, 1'b1));
		send_item(make_item(ACT_ADD, 32'd50, 4'd3, 32'd0, 1'b1));
		send_item(make_item(ACT_ADD, 32'd50, 4'd3, 32'd10, 1'b0));
	endtask

	task automatic test_fill_and_update();
		int t;
		send_item(make_item(ACT_ADD, 32'd100, 4'd15, 32'd10, 1'b1));
		for (t = 1; t <= 7; t++)
			send_item(make_item(ACT_ADD, 32'd110, 4'(t), 32'd1, 1'b1));
		// The table is full now: a new type is turned away, a present one is updated.
		send_item(make_item(ACT_ADD, 32'd110, 4'd8, 32'd5, 1'b1));
		send_item(make_item(ACT_ADD, 32'd105, 4'd15, 32'd20, 1'b1));
	endtask

	task automatic test_due_scan();
		// First tick: seven slots due, slot 0 not yet. Second tick: all eight due.
		send_item(make_item(ACT_TICK, 32'd111, 4'd0, 32'd0, 1'b0));
		send_item(make_item(ACT_TICK, 32'd125, 4'd0, 32'd0, 1'b0));
	endtask

	task automatic test_remove();
		send_item(make_item(ACT_REMOVE, 32'd0, 4'd0, 32'd0, 1'b0));
		send_item(make_item(ACT_REMOVE, 32'd0, 4'd9, 32'd0, 1'b0));
		send_item(make_item(ACT_REMOVE, 32'd0, 4'd4, 32'd0, 1'b0));
	endtask

	task automatic test_unused_action();
		send_item(make_item(ACT_UNUSED, 32'hFFFF_FFFF, 4'd15, 32'hFFFF_FFFF, 1'b1));
	endtask

	task automatic test_time_wrap();
		// The new type lands in the slot freed by the remove, with the widest interval.
		// The ticks then cross the 2^32 wrap of the millisecond counter.
		send_item(make_item(ACT_ADD, 32'hFFFF_FFF0, 4'd9, 32'hFFFF_FFFF, 1'b1));
		send_item(make_item(ACT_TICK, 32'hFFFF_FFFF, 4'd0, 32'd0, 1'b0));
		send_item(make_item(ACT_TICK, 32'd5, 4'd0, 32'd0, 1'b0));
		drain_reports();
	endtask

	// Mostly well-formed traffic: ticks at a slowly advancing time and adds of valid types
	// with short intervals, so slots keep falling due. Removes, malformed adds with random
	// fields, time jumps and the unused action make up the rest.
	task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_items);
		in_item_t it;
		int       sent;
		int       r;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				if (r < 3)
					clock_ms = $urandom;
				else
					clock_ms = clock_ms + $urandom_range(0, 25);
				it = make_item(ACT_TICK, clock_ms, 4'($urandom_range(0, 15)), $urandom,
					1'($urandom_range(0, 1)));
			end else if (r < 75) begin
				it = make_item(ACT_ADD, clock_ms, 4'($urandom_range(1, 15)),
					32'($urandom_range(1, 40)), 1'b1);
			end else if (r < 88) begin
				it = make_item(ACT_REMOVE, $urandom, 4'($urandom_range(0, 15)), $urandom,
					1'($urandom_range(0, 1)));
			end else if (r < 96) begin
				it = make_item(ACT_ADD, $urandom, 4'($urandom_range(0, 15)),
					($urandom_range(0, 1) != 0) ? 32'd0 : 32'($urandom),
					1'($urandom_range(0, 1)));
			end else begin
				it = make_item(ACT_UNUSED, $urandom, 4'($urandom_range(0, 15)), $urandom,
					1'($urandom_range(0, 1)));
			end
			send_item(it);
			if (it.action != ACT_UNUSED)
				sent++;
		end
		// Hold off the sender until the block has caught up before the next phase.
		drain_reports();
	endtask

	initial begin
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		in_item         = '0;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		clock_ms        = 32'd1000;
		fail_count      = 0;
		items_sent      = 0;
		ticks_sent      = 0;
		reports_checked = 0;
		due_reports     = 0;
		biggest_burst   = 0;
		full_rejects    = 0;
		tbl_count       = 0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			tbl_used[i]   = 1'b0;
			tbl_type[i]   = '0;
			tbl_period[i] = '0;
			tbl_stamp[i]  = '0;
		end

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part, with both sides always ready.
		test_empty_tick();
		test_add_rejects();
		test_fill_and_update();
		test_due_scan();
		test_remove();
		test_unused_action();
		test_time_wrap();

		// Random part under the four idling phases.
		test_random_traffic(0, 0, 45);
		test_random_traffic(68, 0, 45);
		test_random_traffic(0, 68, 45);
		test_random_traffic(10, 10, 45);

		// Give the block a full scan's worth of time to show any stray report.
		recv_stall_pct = 0;
		repeat (4 * (NUM_SLOTS + 2)) @(negedge clk);

		$display("Covered %0d items (%0d ticks), %0d reports checked, %0d due reports,",
			items_sent, ticks_sent, reports_checked, due_reports);
		$display("largest due burst %0d, %0d adds refused by a full table.",
			biggest_burst, full_rejects);
		if (fail_count == 0 && pending_reports.size() == 0) begin
			$display("** periodic_report_slot_scheduler_unit: PASSED **");
		end else begin
			$display("** periodic_report_slot_scheduler_unit: FAILED **");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run of this stimulus.
	initial begin
		#2_000_000;
		$display("Timeout with %0d reports still expected.", pending_reports.size());
		$display("** periodic_report_slot_scheduler_unit: FAILED **");
		$finish;
	end

endmodule
